/* rtl/core/stt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_pkg: shared types, codes and byte classes for the source tokenizer
// Token kinds, error codes, result entry layout and character helpers.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int unsigned POSITION_BITS_DEF = 16;
  localparam int unsigned OFFSET_BITS_DEF   = 24;

  // token kinds
  localparam logic [5:0] K_END = 6'd0,  K_INT = 6'd1,  K_FLOAT = 6'd2,  K_CHAR = 6'd3;
  localparam logic [5:0] K_STRING = 6'd4, K_IDENT = 6'd5, K_BOOL = 6'd6;
  localparam logic [5:0] K_TILDE = 6'd7, K_LPAR = 6'd8, K_RPAR = 6'd9, K_LBRACE = 6'd10;
  localparam logic [5:0] K_RBRACE = 6'd11, K_COMMA = 6'd12, K_COLON = 6'd13, K_SEMI = 6'd14;
  localparam logic [5:0] K_PLUS = 6'd15, K_PLUS_EQ = 6'd16, K_MINUS = 6'd17;
  localparam logic [5:0] K_MINUS_EQ = 6'd18, K_ARROW = 6'd19;
  localparam logic [5:0] K_STAR = 6'd20, K_STAR_EQ = 6'd21, K_SLASH = 6'd22;
  localparam logic [5:0] K_SLASH_EQ = 6'd23, K_PCT = 6'd24, K_PCT_EQ = 6'd25;
  localparam logic [5:0] K_AMP = 6'd26, K_AMP_EQ = 6'd27, K_AND = 6'd28;
  localparam logic [5:0] K_PIPE = 6'd29, K_PIPE_EQ = 6'd30, K_OR = 6'd31;
  localparam logic [5:0] K_CARET = 6'd32, K_CARET_EQ = 6'd33;
  localparam logic [5:0] K_GT = 6'd34, K_GE = 6'd35, K_SHR = 6'd36, K_SHR_EQ = 6'd37;
  localparam logic [5:0] K_LT = 6'd38, K_LE = 6'd39, K_SHL = 6'd40, K_SHL_EQ = 6'd41;
  localparam logic [5:0] K_ASSIGN = 6'd42, K_EQ = 6'd43, K_NOT = 6'd44, K_NE = 6'd45;
  localparam logic [5:0] K_LAST_SINGLE = K_SEMI;

  // error codes
  localparam logic [2:0] E_NONE = 3'd0, E_UNHANDLED = 3'd1, E_BAD_DOT = 3'd2;
  localparam logic [2:0] E_CHAR = 3'd3, E_STRING = 3'd4, E_COMMENT = 3'd5;

  // keyword tracker: t-r-u-e runs 1..4, f-a-l-s-e runs 5..9
  localparam logic [3:0] KW_NONE = 4'd0, KW_T = 4'd1, KW_TRUE = 4'd4;
  localparam logic [3:0] KW_F = 4'd5, KW_FALSE = 4'd9;

  localparam logic [7:0] CH_NUL = 8'h00, CH_LF = 8'h0A, CH_DOT = 8'h2E, CH_USCORE = 8'h5F;

  typedef struct packed {
    logic [5:0]  kind;
    logic [2:0]  err;
    logic [15:0] row;
    logic [15:0] col;
    logic [23:0] off;
    logic [15:0] len;
    logic [7:0]  chv;
    logic        last;
  } res_t;

  // results of one accepted byte, from lexer to queue
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r1;
    res_t       r0;
  } lex_out_t;

  function automatic logic is_digit(input logic [7:0] b);
    return b inside {["0":"9"]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return b inside {["a":"z"], ["A":"Z"]};
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b inside {" ", [8'd9:8'd13]};
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] c);
    logic [5:0] k;
    case (c)
      "~": k = K_TILDE;   "(": k = K_LPAR;   ")": k = K_RPAR;
      "{": k = K_LBRACE;  "}": k = K_RBRACE; ",": k = K_COMMA;
      ":": k = K_COLON;   ";": k = K_SEMI;   "+": k = K_PLUS;
      "-": k = K_MINUS;   "*": k = K_STAR;   "/": k = K_SLASH;
      "%": k = K_PCT;     "&": k = K_AMP;    "|": k = K_PIPE;
      "^": k = K_CARET;   ">": k = K_GT;     "<": k = K_LT;
      "=": k = K_ASSIGN;  "!": k = K_NOT;
      default: k = K_END;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] pair_kind(input logic [7:0] c, input logic [7:0] b);
    logic [5:0] k;
    k = K_END;
    if (b == "=") begin
      case (c)
        "+": k = K_PLUS_EQ;  "-": k = K_MINUS_EQ; "*": k = K_STAR_EQ;
        "/": k = K_SLASH_EQ; "%": k = K_PCT_EQ;   "&": k = K_AMP_EQ;
        "|": k = K_PIPE_EQ;  "^": k = K_CARET_EQ; ">": k = K_GE;
        "<": k = K_LE;       "=": k = K_EQ;       "!": k = K_NE;
        default: k = K_END;
      endcase
    end else if (c == "-" && b == ">") begin
      k = K_ARROW;
    end else if (c == "&" && b == "&") begin
      k = K_AND;
    end else if (c == "|" && b == "|") begin
      k = K_OR;
    end
    return k;
  endfunction

  function automatic logic [3:0] next_match(input logic [3:0] m, input logic [7:0] b);
    logic [3:0] n;
    n = KW_NONE;
    case (m)
      4'd1: if (b == "r") n = 4'd2;
      4'd2: if (b == "u") n = 4'd3;
      4'd3: if (b == "e") n = KW_TRUE;
      4'd5: if (b == "a") n = 4'd6;
      4'd6: if (b == "l") n = 4'd7;
      4'd7: if (b == "s") n = 4'd8;
      4'd8: if (b == "e") n = KW_FALSE;
      default: n = KW_NONE;
    endcase
    return n;
  endfunction

endpackage

/* rtl/core/stt_lexer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_lexer: front end of the tokenizer
// Classifies each byte against the lexer mode and builds up to two results.
// ----------------------------------------------------------------------------
module stt_lexer
  import stt_pkg::*;
#(
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF,
  parameter int unsigned OFFSET_BITS   = OFFSET_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] byte_i,
  input  logic       sot_i,
  output lex_out_t   out_o
);

  localparam logic [3:0] M_IDLE = 4'd0, M_NUMBER = 4'd1, M_IDENT = 4'd2;
  localparam logic [3:0] M_CHAR_OPEN = 4'd3, M_CHAR_CLOSE = 4'd4, M_STRING = 4'd5;
  localparam logic [3:0] M_OP1 = 4'd6, M_OP2 = 4'd7, M_LINE = 4'd8, M_BLOCK = 4'd9;
  localparam logic [3:0] M_DONE = 4'd10;

  logic [3:0]               mode_q, mode_d, e_mode;
  logic [POSITION_BITS-1:0] row_q, row_d, e_row, col_q, col_d, e_col;
  logic [POSITION_BITS-1:0] srow_q, srow_d, e_srow, scol_q, scol_d, e_scol;
  logic [OFFSET_BITS-1:0]   off_q, off_d, e_off, soff_q, soff_d, e_soff;
  logic [15:0]              len_q, len_d, e_len;
  logic                     dot_q, dot_d, e_dot;
  logic [3:0]               kw_q, kw_d, e_kw;
  logic [7:0]               held_q, held_d, e_held;
  logic                     halt_q, halt_d, e_halt;
  logic                     newline, go_idle;
  logic [1:0]               n;
  res_t                     res [2];
  logic [5:0]               k;

  function automatic res_t make_res(input logic [5:0] kind, input logic [2:0] err,
                                    input logic [POSITION_BITS-1:0] row,
                                    input logic [POSITION_BITS-1:0] col,
                                    input logic [OFFSET_BITS-1:0] off,
                                    input logic [15:0] len, input logic [7:0] chv);
    res_t r;
    r.kind = kind;
    r.err  = err;
    r.row  = 16'(row);
    r.col  = 16'(col);
    r.off  = 24'(off);
    r.len  = len;
    r.chv  = chv;
    r.last = 1'b0;
    return r;
  endfunction

  always_comb begin
    // start of text restarts everything before this byte
    if (sot_i) begin
      e_mode = M_IDLE;  e_row = POSITION_BITS'(1); e_col = POSITION_BITS'(1);
      e_off = '0; e_srow = '0; e_scol = '0; e_soff = '0; e_len = '0;
      e_dot = 1'b0; e_kw = KW_NONE; e_held = CH_NUL; e_halt = 1'b0;
    end else begin
      e_mode = mode_q; e_row = row_q; e_col = col_q; e_off = off_q;
      e_srow = srow_q; e_scol = scol_q; e_soff = soff_q; e_len = len_q;
      e_dot = dot_q; e_kw = kw_q; e_held = held_q; e_halt = halt_q;
    end
    mode_d = e_mode; row_d = e_row; col_d = e_col; off_d = e_off;
    srow_d = e_srow; scol_d = e_scol; soff_d = e_soff; len_d = e_len;
    dot_d = e_dot; kw_d = e_kw; held_d = e_held; halt_d = e_halt;
    newline = 1'b0;
    go_idle = 1'b0;
    n = 2'd0;
    res[0] = '0;
    res[1] = '0;
    k = K_END;

    if (!(e_halt || e_mode == M_DONE)) begin
      case (e_mode)
        M_NUMBER: begin
          if (is_digit(byte_i)) begin
            if (len_d != 16'hFFFF) len_d = len_d + 16'd1;
            held_d = byte_i;
          end else if (byte_i == CH_DOT) begin
            if (dot_d) begin
              res[n[0]] = make_res(K_END, E_BAD_DOT, srow_d, scol_d, soff_d, 16'd1, 8'd0);
              n = n + 2'd1;
              halt_d = 1'b1;
            end else begin
              dot_d = 1'b1;
              if (len_d != 16'hFFFF) len_d = len_d + 16'd1;
              held_d = byte_i;
            end
          end else if (held_d == CH_DOT) begin
            res[n[0]] = make_res(K_END, E_BAD_DOT, srow_d, scol_d, soff_d, 16'd1, 8'd0);
            n = n + 2'd1;
            halt_d = 1'b1;
          end else begin
            res[n[0]] = make_res(dot_d ? K_FLOAT : K_INT, E_NONE, srow_d, scol_d, soff_d,
                                 len_d, 8'd0);
            n = n + 2'd1;
            go_idle = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_alpha(byte_i) || is_digit(byte_i) || byte_i == CH_USCORE) begin
            if (len_d != 16'hFFFF) len_d = len_d + 16'd1;
            kw_d = next_match(kw_d, byte_i);
          end else begin
            res[n[0]] = make_res((kw_d == KW_TRUE || kw_d == KW_FALSE) ? K_BOOL : K_IDENT,
                                 E_NONE, srow_d, scol_d, soff_d, len_d, 8'd0);
            n = n + 2'd1;
            go_idle = 1'b1;
          end
        end
        M_CHAR_OPEN: begin
          if (byte_i == CH_NUL) begin
            res[n[0]] = make_res(K_END, E_CHAR, e_row, e_col, e_off, 16'd1, 8'd0);
            n = n + 2'd1;
            halt_d = 1'b1;
          end else begin
            held_d = byte_i;
            mode_d = M_CHAR_CLOSE;
          end
        end
        M_CHAR_CLOSE: begin
          if (byte_i == "'") begin
            res[n[0]] = make_res(K_CHAR, E_NONE, srow_d, scol_d, soff_d, 16'd3, held_d);
            n = n + 2'd1;
            mode_d = M_IDLE;
          end else begin
            res[n[0]] = make_res(K_END, E_CHAR, e_row, e_col, e_off, 16'd1, 8'd0);
            n = n + 2'd1;
            halt_d = 1'b1;
          end
        end
        M_STRING: begin
          if (byte_i == "\"") begin
            res[n[0]] = make_res(K_STRING, E_NONE, srow_d, scol_d, soff_d, len_d, 8'd0);
            n = n + 2'd1;
            mode_d = M_IDLE;
          end else if (byte_i == CH_NUL) begin
            res[n[0]] = make_res(K_END, E_STRING, e_row, e_col, e_off, 16'd1, 8'd0);
            n = n + 2'd1;
            halt_d = 1'b1;
          end else if (len_d != 16'hFFFF) begin
            len_d = len_d + 16'd1;
          end
        end
        M_OP1: begin
          k = pair_kind(held_d, byte_i);
          if (held_d == "/" && byte_i == "/") begin
            mode_d = M_LINE;
          end else if (held_d == "/" && byte_i == "*") begin
            mode_d = M_BLOCK;
            dot_d  = 1'b0;
          end else if ((held_d == ">" || held_d == "<") && byte_i == held_d) begin
            mode_d = M_OP2;
          end else if (k != K_END) begin
            res[n[0]] = make_res(k, E_NONE, srow_d, scol_d, soff_d, 16'd2, 8'd0);
            n = n + 2'd1;
            mode_d = M_IDLE;
          end else begin
            res[n[0]] = make_res(single_kind(held_d), E_NONE, srow_d, scol_d, soff_d,
                                 16'd1, 8'd0);
            n = n + 2'd1;
            go_idle = 1'b1;
          end
        end
        M_OP2: begin
          if (byte_i == "=") begin
            res[n[0]] = make_res(held_d == ">" ? K_SHR_EQ : K_SHL_EQ, E_NONE, srow_d, scol_d,
                                 soff_d, 16'd3, 8'd0);
            n = n + 2'd1;
            mode_d = M_IDLE;
          end else begin
            res[n[0]] = make_res(held_d == ">" ? K_SHR : K_SHL, E_NONE, srow_d, scol_d,
                                 soff_d, 16'd2, 8'd0);
            n = n + 2'd1;
            go_idle = 1'b1;
          end
        end
        M_LINE: begin
          if (byte_i == CH_LF || byte_i == CH_NUL) go_idle = 1'b1;
        end
        M_BLOCK: begin
          if (byte_i == CH_NUL) begin
            res[n[0]] = make_res(K_END, E_COMMENT, e_row, e_col, e_off, 16'd1, 8'd0);
            n = n + 2'd1;
            halt_d = 1'b1;
          end else if (dot_d && byte_i == "/") begin
            mode_d = M_IDLE;
          end else begin
            dot_d = (byte_i == "*");
          end
        end
        default: go_idle = 1'b1;
      endcase

      // byte starts something new (or ends the text)
      if (go_idle) begin
        mode_d = M_IDLE;
        k = single_kind(byte_i);
        if (byte_i == CH_NUL) begin
          res[n[0]] = make_res(K_END, E_NONE, e_row, e_col, e_off, 16'd0, 8'd0);
          n = n + 2'd1;
          mode_d = M_DONE;
        end else if (is_space(byte_i)) begin
          newline = (byte_i == CH_LF);
        end else if (is_digit(byte_i) || byte_i == CH_DOT) begin
          srow_d = e_row; scol_d = e_col; soff_d = e_off; len_d = 16'd1;
          mode_d = M_NUMBER;
          dot_d  = (byte_i == CH_DOT);
          held_d = byte_i;
        end else if (is_alpha(byte_i) || byte_i == CH_USCORE) begin
          srow_d = e_row; scol_d = e_col; soff_d = e_off; len_d = 16'd1;
          mode_d = M_IDENT;
          kw_d = (byte_i == "t") ? KW_T : (byte_i == "f") ? KW_F : KW_NONE;
        end else if (byte_i == "'") begin
          srow_d = e_row; scol_d = e_col; soff_d = e_off; len_d = 16'd1;
          mode_d = M_CHAR_OPEN;
        end else if (byte_i == "\"") begin
          srow_d = e_row; scol_d = e_col; soff_d = e_off; len_d = 16'd0;
          mode_d = M_STRING;
        end else if (k == K_END) begin
          res[n[0]] = make_res(K_END, E_UNHANDLED, e_row, e_col, e_off, 16'd1, 8'd0);
          n = n + 2'd1;
          halt_d = 1'b1;
        end else begin
          srow_d = e_row; scol_d = e_col; soff_d = e_off; len_d = 16'd1;
          if (k <= K_LAST_SINGLE) begin
            res[n[0]] = make_res(k, E_NONE, e_row, e_col, e_off, 16'd1, 8'd0);
            n = n + 2'd1;
          end else begin
            mode_d = M_OP1;
            held_d = byte_i;
          end
        end
      end

      if (newline) begin
        if (e_row != '1) row_d = e_row + POSITION_BITS'(1);
        col_d = POSITION_BITS'(1);
      end else if (e_col != '1) begin
        col_d = e_col + POSITION_BITS'(1);
      end
      if (e_off != '1) off_d = e_off + OFFSET_BITS'(1);
    end

    if (n == 2'd2) res[1].last = 1'b1;
    else           res[0].last = 1'b1;
  end

  assign out_o.cnt = n;
  assign out_o.r0  = res[0];
  assign out_o.r1  = res[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE; row_q <= POSITION_BITS'(1); col_q <= POSITION_BITS'(1);
      off_q <= '0; srow_q <= '0; scol_q <= '0; soff_q <= '0; len_q <= '0;
      dot_q <= 1'b0; kw_q <= KW_NONE; held_q <= CH_NUL; halt_q <= 1'b0;
    end else if (accept_i) begin
      mode_q <= mode_d; row_q <= row_d; col_q <= col_d; off_q <= off_d;
      srow_q <= srow_d; scol_q <= scol_d; soff_q <= soff_d; len_q <= len_d;
      dot_q <= dot_d; kw_q <= kw_d; held_q <= held_d; halt_q <= halt_d;
    end
  end

endmodule

/* rtl/core/stt_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_queue: result queue and output side of the tokenizer
// With room takes 0-2 results per cycle; hands out one per cycle when ready.
// ----------------------------------------------------------------------------
module stt_queue
  import stt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  lex_out_t in_i,
  output logic     room_o,
  output logic     valid_o,
  input  logic     ready_i,
  output res_t     head_o
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned AW    = $clog2(DEPTH);

  res_t          mem_q [DEPTH];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   count_q, count_d;
  logic [1:0]    push_cnt;
  logic          pop;

  assign push_cnt = push_i ? in_i.cnt : 2'd0;
  assign pop      = valid_o && ready_i;
  assign valid_o  = (count_q != '0);
  assign head_o   = mem_q[rp_q];
  // room for the worst case of two results from one byte
  assign room_o   = (count_q <= (AW + 1)'(DEPTH - 2));
  assign count_d  = count_q + (AW + 1)'(push_cnt) - (AW + 1)'(pop);

  always_ff @(posedge clk_i) begin
    if (push_cnt != 2'd0) mem_q[wp_q] <= in_i.r0;
    if (push_cnt == 2'd2) mem_q[wp_q + AW'(1)] <= in_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      count_q <= '0;
    end else begin
      wp_q    <= wp_q + AW'(push_cnt);
      rp_q    <= rp_q + AW'(pop);
      count_q <= count_d;
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (AW + 1)'(DEPTH))
    else $error("result queue overflow");

  a_push_fits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_cnt != 2'd0) |-> room_o)
    else $error("push without room");

  a_count_track : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_cnt == 2'd0 && pop) |=> (count_q == $past(count_q) - (AW + 1)'(1)))
    else $error("count lost a pop");

endmodule

/* rtl/core/source_text_tokenizer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_text_tokenizer_top: streaming C-like lexer, one byte per item
// Lexer front end feeding a four-entry result queue.
// ----------------------------------------------------------------------------
// Results are registered: each is written into the result queue when the byte
// that completes it is accepted and presented from the queue head. One byte
// per cycle is taken; input ready drops while fewer than two queue entries are
// free. A byte causing two results is absorbed by the four-entry result queue.
// Reset: asynchronous, active low; lexer idle at row 1, column 1, queue empty.
module source_text_tokenizer_top
  import stt_pkg::*;
#(
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF,
  parameter int unsigned OFFSET_BITS   = OFFSET_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] text_byte
  input  logic        s_axis_tuser_i,   // [0] start_of_text
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [2:0] error_code, [18:3] start_row, [34:19] start_column,
  // [58:35] start_offset, [74:59] token_length, [82:75] char_value, [87:83] zero
  output logic [87:0] m_axis_tdata_o,
  output logic [5:0]  m_axis_tuser_o,   // [5:0] token_kind
  output logic        m_axis_tlast_o
);

  lex_out_t lex_out;
  res_t     head;
  logic     accept;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  stt_lexer #(
    .POSITION_BITS(POSITION_BITS),
    .OFFSET_BITS  (OFFSET_BITS)
  ) u_lexer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .byte_i  (s_axis_tdata_i),
    .sot_i   (s_axis_tuser_i),
    .out_o   (lex_out)
  );

  stt_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .in_i   (lex_out),
    .room_o (s_axis_tready_o),
    .valid_o(m_axis_tvalid_o),
    .ready_i(m_axis_tready_i),
    .head_o (head)
  );

  assign m_axis_tdata_o = {5'd0, head.chv, head.len, head.off, head.col, head.row, head.err};
  assign m_axis_tuser_o = head.kind;
  assign m_axis_tlast_o = head.last;

endmodule

/* sim/source_text_tokenizer_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_text_tokenizer_top_test: self-checking bench for the source tokenizer
// Drives source bytes through the input stream, predicts every token and error
// with a behavioral lexer in the bench, and compares each result item in order.
// ----------------------------------------------------------------------------
module source_text_tokenizer_top_test;
  import stt_pkg::*;

  typedef enum logic [3:0] {
    LX_IDLE, LX_NUMBER, LX_IDENT, LX_CHAR_OPEN, LX_CHAR_CLOSE, LX_STRING,
    LX_OP1, LX_OP2, LX_LINE, LX_BLOCK, LX_DONE
  } lx_mode_e;

  localparam int WATCHDOG_LIMIT = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;
  logic        s_axis_tuser_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [87:0] m_axis_tdata_o;
  logic [5:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  source_text_tokenizer_top u_top (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // lexer state mirrored in the bench
  lx_mode_e    lx_mode;
  logic [15:0] cur_row, cur_col, tok_row, tok_col, tok_len;
  logic [23:0] cur_off, tok_off;
  logic        dot_flag, lx_halt, nl_seen;
  logic [3:0]  kw_state;
  logic [7:0]  held;
  res_t        step_res[$];

  res_t        token_queue[$];
  int          mismatch_count = 0;
  int          idle_cycles = 0;

  function automatic bit is_dig(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit is_alp(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic [5:0] one_char_kind(logic [7:0] c);
    case (c)
      "~": return K_TILDE;  "(": return K_LPAR;   ")": return K_RPAR;
      "{": return K_LBRACE; "}": return K_RBRACE; ",": return K_COMMA;
      ":": return K_COLON;  ";": return K_SEMI;   "+": return K_PLUS;
      "-": return K_MINUS;  "*": return K_STAR;   "/": return K_SLASH;
      "%": return K_PCT;    "&": return K_AMP;    "|": return K_PIPE;
      "^": return K_CARET;  ">": return K_GT;     "<": return K_LT;
      "=": return K_ASSIGN; "!": return K_NOT;
      default: return K_END;
    endcase
  endfunction

  function automatic logic [5:0] two_char_kind(logic [7:0] c, logic [7:0] b);
    if (b == "=") begin
      case (c)
        "+": return K_PLUS_EQ;  "-": return K_MINUS_EQ; "*": return K_STAR_EQ;
        "/": return K_SLASH_EQ; "%": return K_PCT_EQ;   "&": return K_AMP_EQ;
        "|": return K_PIPE_EQ;  "^": return K_CARET_EQ; ">": return K_GE;
        "<": return K_LE;       "=": return K_EQ;       "!": return K_NE;
        default: return K_END;
      endcase
    end
    if (c == "-" && b == ">") return K_ARROW;
    if (c == "&" && b == "&") return K_AND;
    if (c == "|" && b == "|") return K_OR;
    return K_END;
  endfunction

  task automatic push_result(logic [5:0] kind, logic [2:0] err, logic [15:0] row,
                             logic [15:0] col, logic [23:0] off, logic [15:0] len,
                             logic [7:0] chv);
    res_t r;
    r = '{kind: kind, err: err, row: row, col: col, off: off, len: len, chv: chv,
          last: 1'b0};
    if (step_res.size() < 2) step_res = {step_res, r};
  endtask

  task automatic push_token(logic [5:0] kind, logic [15:0] len, logic [7:0] chv);
    push_result(kind, E_NONE, tok_row, tok_col, tok_off, len, chv);
  endtask

  task automatic error_here(logic [2:0] code);
    push_result(K_END, code, cur_row, cur_col, cur_off, 16'd1, 8'd0);
    lx_halt = 1'b1;
  endtask

  task automatic error_at_start(logic [2:0] code);
    push_result(K_END, code, tok_row, tok_col, tok_off, 16'd1, 8'd0);
    lx_halt = 1'b1;
  endtask

  task automatic open_token(lx_mode_e m);
    tok_row = cur_row;
    tok_col = cur_col;
    tok_off = cur_off;
    tok_len = 16'd1;
    lx_mode = m;
  endtask

  task automatic grow_length();
    if (tok_len != 16'hFFFF) tok_len++;
  endtask

  task automatic clear_lexer();
    lx_mode = LX_IDLE;
    cur_row = 16'd1;
    cur_col = 16'd1;
    cur_off = '0;
    tok_row = '0;
    tok_col = '0;
    tok_off = '0;
    tok_len = '0;
    dot_flag = 1'b0;
    kw_state = KW_NONE;
    held = '0;
    lx_halt = 1'b0;
  endtask

  task automatic lex_from_idle(logic [7:0] b);
    logic [5:0] k;
    lx_mode = LX_IDLE;
    if (b == CH_NUL) begin
      push_result(K_END, E_NONE, cur_row, cur_col, cur_off, 16'd0, 8'd0);
      lx_mode = LX_DONE;
    end else if (b == " " || (b >= 8'd9 && b <= 8'd13)) begin
      if (b == CH_LF) nl_seen = 1'b1;
    end else if (is_dig(b) || b == CH_DOT) begin
      open_token(LX_NUMBER);
      dot_flag = (b == CH_DOT);
      held = b;
    end else if (is_alp(b) || b == CH_USCORE) begin
      open_token(LX_IDENT);
      kw_state = (b == "t") ? KW_T : (b == "f") ? KW_F : KW_NONE;
    end else if (b == "'") begin
      open_token(LX_CHAR_OPEN);
    end else if (b == "\"") begin
      open_token(LX_STRING);
      tok_len = '0;
    end else begin
      k = one_char_kind(b);
      if (k == K_END) begin
        error_here(E_UNHANDLED);
      end else if (k <= K_LAST_SINGLE) begin
        open_token(LX_IDLE);
        push_token(k, 16'd1, 8'd0);
      end else begin
        open_token(LX_OP1);
        held = b;
      end
    end
  endtask

  function automatic logic [3:0] keyword_next(logic [3:0] m, logic [7:0] b);
    case (m)
      4'd1: return (b == "r") ? 4'd2 : KW_NONE;
      4'd2: return (b == "u") ? 4'd3 : KW_NONE;
      4'd3: return (b == "e") ? KW_TRUE : KW_NONE;
      4'd5: return (b == "a") ? 4'd6 : KW_NONE;
      4'd6: return (b == "l") ? 4'd7 : KW_NONE;
      4'd7: return (b == "s") ? 4'd8 : KW_NONE;
      4'd8: return (b == "e") ? KW_FALSE : KW_NONE;
      default: return KW_NONE;
    endcase
  endfunction

  // advance the lexer by one byte and queue the tokens it completes
  task automatic lex_byte(logic [7:0] b, logic restart);
    logic [5:0] k;
    if (restart) clear_lexer();
    step_res.delete();
    nl_seen = 1'b0;
    if (lx_halt || lx_mode == LX_DONE) return;
    case (lx_mode)
      LX_NUMBER: begin
        if (is_dig(b)) begin
          grow_length();
          held = b;
        end else if (b == CH_DOT) begin
          if (dot_flag) error_at_start(E_BAD_DOT);
          else begin
            dot_flag = 1'b1;
            grow_length();
            held = b;
          end
        end else if (held == CH_DOT) begin
          error_at_start(E_BAD_DOT);
        end else begin
          push_token(dot_flag ? K_FLOAT : K_INT, tok_len, 8'd0);
          lex_from_idle(b);
        end
      end
      LX_IDENT: begin
        if (is_alp(b) || is_dig(b) || b == CH_USCORE) begin
          grow_length();
          kw_state = keyword_next(kw_state, b);
        end else begin
          push_token((kw_state == KW_TRUE || kw_state == KW_FALSE) ? K_BOOL : K_IDENT,
                     tok_len, 8'd0);
          lex_from_idle(b);
        end
      end
      LX_CHAR_OPEN: begin
        if (b == CH_NUL) error_here(E_CHAR);
        else begin
          held = b;
          lx_mode = LX_CHAR_CLOSE;
        end
      end
      LX_CHAR_CLOSE: begin
        if (b == "'") begin
          push_token(K_CHAR, 16'd3, held);
          lx_mode = LX_IDLE;
        end else error_here(E_CHAR);
      end
      LX_STRING: begin
        if (b == "\"") begin
          push_token(K_STRING, tok_len, 8'd0);
          lx_mode = LX_IDLE;
        end else if (b == CH_NUL) error_here(E_STRING);
        else grow_length();
      end
      LX_OP1: begin
        k = two_char_kind(held, b);
        if (held == "/" && b == "/") lx_mode = LX_LINE;
        else if (held == "/" && b == "*") begin
          lx_mode = LX_BLOCK;
          dot_flag = 1'b0;
        end else if ((held == ">" || held == "<") && b == held) lx_mode = LX_OP2;
        else if (k != K_END) begin
          push_token(k, 16'd2, 8'd0);
          lx_mode = LX_IDLE;
        end else begin
          push_token(one_char_kind(held), 16'd1, 8'd0);
          lex_from_idle(b);
        end
      end
      LX_OP2: begin
        if (b == "=") begin
          push_token(held == ">" ? K_SHR_EQ : K_SHL_EQ, 16'd3, 8'd0);
          lx_mode = LX_IDLE;
        end else begin
          push_token(held == ">" ? K_SHR : K_SHL, 16'd2, 8'd0);
          lex_from_idle(b);
        end
      end
      LX_LINE: if (b == CH_LF || b == CH_NUL) lex_from_idle(b);
      LX_BLOCK: begin
        if (b == CH_NUL) error_here(E_COMMENT);
        else if (dot_flag && b == "/") lx_mode = LX_IDLE;
        else dot_flag = (b == "*");
      end
      default: lex_from_idle(b);
    endcase
    if (nl_seen) begin
      if (cur_row != 16'hFFFF) cur_row++;
      cur_col = 16'd1;
    end else if (cur_col != 16'hFFFF) begin
      cur_col++;
    end
    if (cur_off != 24'hFFFFFF) cur_off++;
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
    foreach (step_res[i]) token_queue = {token_queue, step_res[i]};
  endtask

  // sender: bursts with random gaps
  int burst_left = 0;

  task automatic send_byte(logic [7:0] b, logic restart);
    if (burst_left == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tuser_i  <= restart;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    lex_byte(b, restart);
  endtask

  // string literals drop NUL bytes, so end of text is sent with send_byte
  task automatic send_text(string s, bit restart);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], restart && i == 0);
  endtask

  // receiver: alternates stall-free stretches with random stalling
  int stall_phase = 0;
  always @(posedge clk_i) begin
    stall_phase <= (stall_phase + 1) % 200;
    if (stall_phase < 60) m_axis_tready_i <= 1'b1;
    else m_axis_tready_i <= ($urandom_range(0, 2) != 0);
  end

  always @(posedge clk_i) begin
    res_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = '{kind: m_axis_tuser_o, err: m_axis_tdata_o[2:0], row: m_axis_tdata_o[18:3],
              col: m_axis_tdata_o[34:19], off: m_axis_tdata_o[58:35],
              len: m_axis_tdata_o[74:59], chv: m_axis_tdata_o[82:75],
              last: m_axis_tlast_o};
      if (token_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result item %p", got);
      end else begin
        want = token_queue.pop_front();
        if (got !== want || m_axis_tdata_o[87:83] !== 5'd0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("result mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic test_operators();
    send_text("~(){},:;+ += - -= -> * *= / /= % %= & &= && | |= || ^ ^=", 1);
    send_text(" > >= >> >>= < <= << <<= = == ! != >>x<<y>>>", 0);
    send_text(" ", 0);
    send_byte(CH_NUL, 0);
  endtask

  task automatic test_literals();
    send_text("12 3.5 .7 x_1 _a true false truex fals 'a' '\xff' \"s\\n\" t", 1);
    send_byte(CH_NUL, 0);
    send_text("1.2.3", 1);
    send_text("7.;", 1);
    send_text(". ", 1);
    send_text("'", 1);
    send_byte(CH_NUL, 0);
    send_text("'ab", 1);
    send_text("\"abc", 1);
    send_byte(CH_NUL, 0);
  endtask

  task automatic test_comments();
    send_text("a//x\n\nb/* **/ c /*/ */d//end", 1);
    send_byte(CH_NUL, 0);
    send_text("/* open", 1);
    send_byte(CH_NUL, 0);
    send_text("@", 1);
    send_text("\x80", 1);
    send_text("x\"\n\"\x7f", 1);
  endtask

  task automatic test_random_text();
    string pieces[] = '{"abc", "true", "false", "x9_", "42", "3.14", ".5", "'q'",
                        "\"hi there\"", "+=", "->", "&&", "||", ">>=", "<<", "!=",
                        "==", "/* c*/", "// l\n", "\n", " ", "\t", ";", "(", ")",
                        "{", "}", ",", "1..", "'x", "#", "%="};
    int sent;
    sent = 0;
    while (sent < 1500) begin
      int n;
      n = $urandom_range(5, 40);
      send_byte(pieces[0][0], 1);
      sent++;
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_byte(8'($urandom_range(0, 255)), 0);
          sent++;
        end else begin
          string p;
          p = pieces[$urandom_range(0, pieces.size() - 1)];
          send_text(p, 0);
          sent += p.len();
        end
      end
      if ($urandom_range(0, 3) != 0) begin
        send_byte(CH_NUL, 0);
        sent++;
      end
    end
  endtask

  initial begin
    clear_lexer();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_operators();
    test_literals();
    test_comments();
    test_random_text();
    s_axis_tvalid_i <= 1'b0;
    while (token_queue.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* source_text_tokenizer_top.f */
rtl/core/stt_pkg.sv
rtl/core/stt_lexer.sv
rtl/core/stt_queue.sv
rtl/core/source_text_tokenizer_top.sv
sim/source_text_tokenizer_top_test.sv
